// ----- hdl/apa_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// apa_pkg
// Shared types and constants of the average pool accumulator.
// ---------------------------------------------------------------------------
package apa_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int MULT_W      = 24;
    localparam int CFG_COUNT_W = 9;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int FRAC_SHIFT  = 16;
    localparam int CMD_DEPTH   = 4;
    localparam int OUT_DEPTH   = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MAX    = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       first_tap;
        logic                       last_tap;
        logic [MULT_W-1:0]          pixel_multiplier;
        logic                       last_channel;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] pooled_value;
        logic                       last_channel;
    } res_t;

endpackage
`default_nettype wire

// ----- hdl/apa_fifo.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// apa_fifo
// Small register queue; depth is a power of two.
// ---------------------------------------------------------------------------
module apa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [WIDTH-1:0]           wr_data,
    input  wire logic                       pop,
    output logic      [WIDTH-1:0]           rd_data,
    output logic                            full,
    output logic                            empty,
    output logic      [$clog2(DEPTH):0]     count
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/apa_ram.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// apa_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module apa_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

// ----- hdl/apa_front.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// apa_front
// Accepts items, tracks the channel counter and tags each item with its
// channel and the last-channel mark.
// ---------------------------------------------------------------------------
module apa_front
    import apa_pkg::*;
#(
    parameter int MAX_CHANNELS = 256
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  wire logic                           full,
    input  wire logic signed [SAMPLE_W-1:0]     sample,
    input  wire logic                           first_tap,
    input  wire logic                           last_tap,
    input  wire logic [MULT_W-1:0]              pixel_multiplier,
    input  wire logic [CFG_COUNT_W-1:0]         channel_count,
    output logic                                cmd_push,
    output item_t                               cmd_item,
    output logic [$clog2(MAX_CHANNELS)-1:0]     cmd_idx
);
    localparam int IDX_W = $clog2(MAX_CHANNELS);
    localparam int CW    = ($clog2(MAX_CHANNELS + 1) > CFG_COUNT_W)
                           ? $clog2(MAX_CHANNELS + 1) : CFG_COUNT_W;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CW-1:0]    cnt_ext, eff_cnt, idx_p1;
    logic             last_ch;

    // zero counts as one, anything above the channel store is clipped
    always_comb
    begin
        cnt_ext = CW'(channel_count);
        priority if (cnt_ext == '0)
            eff_cnt = CW'(1);
        else if (cnt_ext > CW'(MAX_CHANNELS))
            eff_cnt = CW'(MAX_CHANNELS);
        else
            eff_cnt = cnt_ext;
        idx_p1  = CW'(idx_reg) + CW'(1);
        last_ch = (idx_p1 >= eff_cnt);
        idx_next = idx_reg;
        if (cmd_push)
        begin
            idx_next = last_ch ? '0 : idx_reg + IDX_W'(1);
        end
    end

    assign cmd_push = push && !full;
    assign cmd_idx  = idx_reg;

    always_comb
    begin
        cmd_item.sample           = sample;
        cmd_item.first_tap        = first_tap;
        cmd_item.last_tap         = last_tap;
        cmd_item.pixel_multiplier = pixel_multiplier;
        cmd_item.last_channel     = last_ch;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/apa_back.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// apa_back
// Accumulator read-modify-write, scaling multiply, rounding and clamping,
// followed by the result queue.
// ---------------------------------------------------------------------------
module apa_back
    import apa_pkg::*;
#(
    parameter int MAX_CHANNELS = 256,
    parameter int MAX_TAPS     = 256
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cmd_empty,
    input  wire item_t                          cmd_item,
    input  wire logic [$clog2(MAX_CHANNELS)-1:0] cmd_idx,
    output logic                                cmd_pop,
    input  wire logic signed [SAMPLE_W-1:0]     out_min,
    input  wire logic signed [SAMPLE_W-1:0]     out_max,
    input  wire logic                           pop,
    output logic                                empty,
    output logic signed [SAMPLE_W-1:0]          pooled_value,
    output logic                                last_channel
);
    localparam int IDX_W  = $clog2(MAX_CHANNELS);
    localparam int SUM_W  = SAMPLE_W + $clog2(MAX_TAPS);
    localparam int PROD_W = SUM_W + MULT_W + 1;
    localparam int V_W    = PROD_W - FRAC_SHIFT;
    localparam int OCNT_W = $clog2(OUT_DEPTH) + 1;
    localparam longint LO_L = -64'sd32768 * longint'(MAX_TAPS);
    localparam longint HI_L = 64'sd32767 * longint'(MAX_TAPS);
    localparam logic signed [SUM_W:0]    LO_B = (SUM_W + 1)'(LO_L);
    localparam logic signed [SUM_W:0]    HI_B = (SUM_W + 1)'(HI_L);
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_SHIFT - 1);

    // stage 1: accumulate
    logic                     s1_valid_reg;
    item_t                    s1_item_reg;
    logic [IDX_W-1:0]         s1_idx_reg;
    // last write, not yet visible to a read issued in the same cycle
    logic                     fwd_valid_reg;
    logic [IDX_W-1:0]         fwd_idx_reg;
    logic signed [SUM_W-1:0]  fwd_sum_reg;
    // stage 2: multiply
    logic                     s2_valid_reg;
    logic signed [SUM_W-1:0]  s2_sum_reg;
    logic [MULT_W-1:0]        s2_mult_reg;
    logic                     s2_last_reg;
    // stage 3: round and clamp
    logic                     s3_valid_reg;
    logic signed [PROD_W-1:0] s3_prod_reg;
    logic                     s3_last_reg;

    logic [SUM_W-1:0]         ram_rdata;
    logic signed [SUM_W-1:0]  base;
    logic signed [SUM_W:0]    add_wide, add_sat;
    logic signed [SUM_W-1:0]  acc;
    logic signed [PROD_W-1:0] prod, prod_half;
    logic signed [V_W-1:0]    v_round, v_lo, v_res, min_ext, max_ext;
    logic                     issue;
    logic [OCNT_W-1:0]        out_count;
    logic [OCNT_W:0]          credits;
    logic                     out_full;
    logic [$bits(res_t)-1:0]  out_bits;
    res_t                     res_in, res_out;

    // room in the result queue for every result still in flight
    assign credits = {1'b0, out_count}
                   + (OCNT_W + 1)'(s1_valid_reg && s1_item_reg.last_tap)
                   + (OCNT_W + 1)'(s2_valid_reg)
                   + (OCNT_W + 1)'(s3_valid_reg);
    assign issue   = !cmd_empty && (credits < (OCNT_W + 1)'(OUT_DEPTH));
    assign cmd_pop = issue;

    apa_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_CHANNELS)
    ) u_sums (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_idx_reg),
        .wdata (acc),
        .raddr (cmd_idx),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        base = (fwd_valid_reg && fwd_idx_reg == s1_idx_reg)
             ? fwd_sum_reg : $signed(ram_rdata);
        add_wide = (SUM_W + 1)'(base) + (SUM_W + 1)'($signed(s1_item_reg.sample));
        priority if (add_wide < LO_B)
            add_sat = LO_B;
        else if (add_wide > HI_B)
            add_sat = HI_B;
        else
            add_sat = add_wide;
        acc = s1_item_reg.first_tap ? SUM_W'($signed(s1_item_reg.sample))
                                    : add_sat[SUM_W-1:0];
    end

    assign prod = $signed(s2_sum_reg) * $signed({1'b0, s2_mult_reg});

    // floor((p + half) / 2^16), then clamp low bound first, high bound last
    always_comb
    begin
        prod_half = s3_prod_reg + HALF;
        v_round   = prod_half[PROD_W-1:FRAC_SHIFT];
        min_ext   = V_W'(out_min);
        max_ext   = V_W'(out_max);
        v_lo      = (v_round < min_ext) ? min_ext : v_round;
        v_res     = (v_lo > max_ext) ? max_ext : v_lo;
        res_in.pooled_value = v_res[SAMPLE_W-1:0];
        res_in.last_channel = s3_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= issue;
            fwd_valid_reg <= s1_valid_reg;
            s2_valid_reg  <= s1_valid_reg && s1_item_reg.last_tap;
            s3_valid_reg  <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= cmd_item;
        s1_idx_reg  <= cmd_idx;
        fwd_idx_reg <= s1_idx_reg;
        fwd_sum_reg <= acc;
        s2_sum_reg  <= acc;
        s2_mult_reg <= s1_item_reg.pixel_multiplier;
        s2_last_reg <= s1_item_reg.last_channel;
        s3_prod_reg <= prod;
        s3_last_reg <= s2_last_reg;
    end

    apa_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (s3_valid_reg),
        .wr_data (res_in),
        .pop     (pop),
        .rd_data (out_bits),
        .full    (out_full),
        .empty   (empty),
        .count   (out_count)
    );

    assign res_out      = res_t'(out_bits);
    assign pooled_value = res_out.pooled_value;
    assign last_channel = res_out.last_channel;

    a_no_out_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> !out_full)
        else $error("result queue overflow");

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credits <= (OCNT_W + 1)'(OUT_DEPTH))
        else $error("more results in flight than queue space");

    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_item_reg.first_tap |->
            ((SUM_W + 1)'(acc) >= LO_B) && ((SUM_W + 1)'(acc) <= HI_B))
        else $error("accumulator outside tap bounds");

    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && (out_min <= out_max) |->
            (res_in.pooled_value >= out_min) && (res_in.pooled_value <= out_max))
        else $error("result outside clamp range");

    a_pop_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> $past(s1_valid_reg))
        else $error("multiply stage without accumulate");

endmodule
`default_nettype wire

// ----- hdl/pixelwise_average_pool_accumulator_unit.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// pixelwise_average_pool_accumulator_unit
// Per-channel tap accumulation with scaling, rounding and clamping.
// ---------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  input     in         push / full        sample, first_tap, last_tap,
//                                          pixel_multiplier
//  result    out        empty / pop        pooled_value, last_channel
//  config    in         cfg_write          cfg_index, cfg_data
//
//  one item per cycle sustained while the result queue has room; the
//  accumulator store has one read and one write port, written back in the
//  cycle after the read, with a forward path
//  reset clears the channel counter and queues; the sum store is not cleared
//  full rises when the four-entry command queue is full; the back end stalls
//  only when the eight-entry result queue has no room for results in flight
// ---------------------------------------------------------------------------
module pixelwise_average_pool_accumulator_unit
    import apa_pkg::*;
#(
    parameter int MAX_CHANNELS = 256,
    parameter int MAX_TAPS     = 256
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic                       first_tap,
    input  wire logic                       last_tap,
    input  wire logic [MULT_W-1:0]          pixel_multiplier,
    output logic                            empty,
    input  wire logic                       pop,
    output logic signed [SAMPLE_W-1:0]      pooled_value,
    output logic                            last_channel,
    input  wire logic                       cfg_write,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data
);
    localparam int IDX_W = $clog2(MAX_CHANNELS);
    localparam int CMD_W = $bits(item_t) + IDX_W;

    logic [CFG_COUNT_W-1:0]     count_reg, count_next;
    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic signed [SAMPLE_W-1:0] max_reg, max_next;

    logic                       cmd_push, cmd_pop, cmd_empty;
    item_t                      fe_item, be_item;
    logic [IDX_W-1:0]           fe_idx, be_idx;
    logic [CMD_W-1:0]           cmd_rd;
    logic [$clog2(CMD_DEPTH):0] cmd_count;

    always_comb
    begin
        count_next = count_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CHANNEL_COUNT: count_next = cfg_data[CFG_COUNT_W-1:0];
                REG_OUTPUT_MIN:    min_next   = $signed(cfg_data);
                REG_OUTPUT_MAX:    max_next   = $signed(cfg_data);
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CFG_COUNT_W'(1);
            min_reg   <= 16'sh8000;
            max_reg   <= 16'sh7fff;
        end
        else
        begin
            count_reg <= count_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
        end
    end

    apa_front #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .sample           (sample),
        .first_tap        (first_tap),
        .last_tap         (last_tap),
        .pixel_multiplier (pixel_multiplier),
        .channel_count    (count_reg),
        .cmd_push         (cmd_push),
        .cmd_item         (fe_item),
        .cmd_idx          (fe_idx)
    );

    // command queue between front and back
    apa_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data ({fe_idx, fe_item}),
        .pop     (cmd_pop),
        .rd_data (cmd_rd),
        .full    (full),
        .empty   (cmd_empty),
        .count   (cmd_count)
    );

    assign be_item = item_t'(cmd_rd[$bits(item_t)-1:0]);
    assign be_idx  = cmd_rd[CMD_W-1:$bits(item_t)];

    apa_back #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_TAPS     (MAX_TAPS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_empty    (cmd_empty),
        .cmd_item     (be_item),
        .cmd_idx      (be_idx),
        .cmd_pop      (cmd_pop),
        .out_min      (min_reg),
        .out_max      (max_reg),
        .pop          (pop),
        .empty        (empty),
        .pooled_value (pooled_value),
        .last_channel (last_channel)
    );

    a_cmd_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && !cmd_push |=> cmd_count == $past(cmd_count) - 1'b1)
        else $error("command queue count lost an entry");

endmodule
`default_nettype wire
